>>> sv/rcit_pkg.sv
package rcit_pkg;

  // Input commands
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_PAUSE  = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_REWIND = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_LOOPS    = 2'd1;
  localparam logic [1:0] REG_TAG      = 2'd2;

  // Result kinds
  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned LOOPS_W    = 17;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned ACC_W      = 33;
  localparam int unsigned DIFF_W     = 34;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_LOOP = 5'b00100,
    ST_ZERO = 5'b01000,
    ST_STOP = 5'b10000
  } state_e;

endpackage

>>> sv/repeat_count_interval_timer.sv
// Sequence: a tick has an accept cycle in idle and then a compare state, then gives each result
//   (fire or stop) in turn, held by any output stall; a tick that fires nothing spends the
//   loop or zero state finding that out. Start, pause, stop, rewind and idle ticks finish in
//   the accept cycle. No new command is taken until a tick is done, and while the output
//   is free the shared 34-bit subtractor walks the accumulator down one interval per cycle.
// Reset: asynchronous, active low; timer stopped, accumulator, loops and registers zero.
module repeat_count_interval_timer
  import rcit_pkg::*;
#(
  parameter int unsigned MAX_FIRES = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  // command beats
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            command_i,
  input  logic [INTERVAL_W-1:0] elapsed_us_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic [TAG_W-1:0]      tag_o,
  output logic                  last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FIRES + 1);

  // Configuration registers
  logic [INTERVAL_W-1:0]    interval_q, interval_d;
  logic signed [LOOPS_W-1:0] loop_count_q, loop_count_d;
  logic [TAG_W-1:0]         tag_q, tag_d;

  // Timer state
  logic                      running_q, running_d;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic signed [LOOPS_W-1:0] loops_q, loops_d;

  // Sequencer
  state_e                    state_q, state_d;
  logic [DIFF_W-1:0]         diff_q, diff_d;    // accumulator minus interval
  logic [CNT_W-1:0]          fires_q, fires_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic                      kind_q, kind_d;
  logic [TAG_W-1:0]          otag_q, otag_d;
  logic                      last_q, last_d;

  logic                      in_accept;
  logic                      out_free;
  logic [DIFF_W-1:0]         sum;
  logic [ACC_W-1:0]          acc_sat;
  logic [DIFF_W-1:0]         interval_ext;
  logic [DIFF_W-1:0]         diff_next;
  logic                      loops_pos;
  logic signed [LOOPS_W-1:0] loops_next;
  logic                      more;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign interval_ext = {2'b00, interval_q};
  assign sum          = {1'b0, acc_q} + {2'b00, elapsed_us_i};
  // Add elapsed time, saturate at the accumulator limit.
  assign acc_sat      = sum[DIFF_W-1] ? '1 : sum[ACC_W-1:0];
  // Shared subtractor: next remainder after taking one more interval.
  assign diff_next    = diff_q - interval_ext;
  assign loops_pos    = !loops_q[LOOPS_W-1] && (loops_q != '0);
  assign loops_next   = loops_pos ? loops_q - LOOPS_W'(1) : loops_q;
  // Another fire follows this one in the same tick.
  assign more         = ((fires_q + CNT_W'(1)) != CNT_W'(MAX_FIRES)) &&
                        (loops_next != '0) && !diff_next[DIFF_W-1];

  always_comb begin
    interval_d   = interval_q;
    loop_count_d = loop_count_q;
    tag_d        = tag_q;
    running_d    = running_q;
    acc_d        = acc_q;
    loops_d      = loops_q;
    state_d      = state_q;
    diff_d       = diff_q;
    fires_d      = fires_q;
    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    otag_d       = otag_q;
    last_d       = last_q;

    // Register writes must arrive only while idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INTERVAL: interval_d = cfg_wdata_i;
        REG_LOOPS: begin
          loop_count_d = cfg_wdata_i[LOOPS_W-1:0];
          loops_d      = cfg_wdata_i[LOOPS_W-1:0];
        end
        REG_TAG:      tag_d = cfg_wdata_i[TAG_W-1:0];
        default:      ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (command_i)
            CMD_TICK: begin
              if (running_q && (interval_q != '0)) begin
                // Load the saturated sum; the compare cycle takes the first interval off.
                acc_d   = acc_sat;
                diff_d  = {1'b0, acc_sat};
                fires_d = '0;
                state_d = ST_CMP;
              end
            end
            CMD_START: running_d = 1'b1;
            CMD_PAUSE: running_d = 1'b0;
            CMD_STOP: begin
              running_d = 1'b0;
              acc_d     = '0;
              loops_d   = loop_count_q;
            end
            CMD_REWIND: begin
              acc_d   = '0;
              loops_d = loop_count_q;
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        diff_d  = diff_next;
        state_d = (loops_q == '0) ? ST_ZERO : ST_LOOP;
      end
      ST_LOOP: begin
        if (diff_q[DIFF_W-1]) begin
          // Less than one interval held: nothing to fire.
          state_d = ST_IDLE;
        end else if (out_free) begin
          acc_d       = diff_q[ACC_W-1:0];
          diff_d      = diff_next;
          loops_d     = loops_next;
          fires_d     = fires_q + CNT_W'(1);
          out_valid_d = 1'b1;
          kind_d      = KIND_FIRE;
          otag_d      = tag_q;
          last_d      = !more;
          if (!more) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ZERO: begin
        if (diff_q[DIFF_W-1]) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_FIRE;
          otag_d      = tag_q;
          last_d      = 1'b0;
          state_d     = ST_STOP;
        end
      end
      ST_STOP: begin
        if (out_free) begin
          // Final fire delivered: stop and rewind.
          running_d   = 1'b0;
          acc_d       = '0;
          loops_d     = loop_count_q;
          out_valid_d = 1'b1;
          kind_d      = KIND_STOP;
          otag_d      = tag_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= '0;
      loop_count_q <= '0;
      tag_q        <= '0;
      running_q    <= 1'b0;
      acc_q        <= '0;
      loops_q      <= '0;
      state_q      <= ST_IDLE;
      fires_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      interval_q   <= interval_d;
      loop_count_q <= loop_count_d;
      tag_q        <= tag_d;
      running_q    <= running_d;
      acc_q        <= acc_d;
      loops_q      <= loops_d;
      state_q      <= state_d;
      fires_q      <= fires_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    kind_q <= kind_d;
    otag_q <= otag_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tag_o       = otag_q;
  assign last_o      = last_q;

  // A stop result always closes its tick.
  a_stop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STOP) |-> last_o)
    else $error("stop result without last");

  // Emitting the stop result leaves the timer stopped and rewound.
  a_stop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STOP) && out_free |=> !running_q && (acc_q == '0))
    else $error("timer not rewound after stop");

  // Fires per tick never exceed the limit.
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= CNT_W'(MAX_FIRES))
    else $error("fire limit exceeded");

  // No new command is taken while a tick is still being worked.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOP) || (state_q == ST_ZERO) || (state_q == ST_STOP) |-> !in_accept)
    else $error("command accepted while busy");

endmodule

>>> tb/repeat_count_interval_timer_checker.sv
`timescale 1ns / 1ps

module repeat_count_interval_timer_checker
  import rcit_pkg::*;
#(
  parameter int unsigned MAX_FIRES = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [2:0]            command_i,
  input  logic [INTERVAL_W-1:0] elapsed_us_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  kind_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic                  last_i,
  output int                    error_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_event_t;

  localparam logic [ACC_W-1:0] ACC_CEILING = {ACC_W{1'b1}};

  // shadow registers and timer state
  logic [INTERVAL_W-1:0]     interval_q;
  logic signed [LOOPS_W-1:0] loop_count_q;
  logic [TAG_W-1:0]          tag_q;
  logic                      running_q;
  logic [ACC_W-1:0]          acc_us_q;
  logic signed [LOOPS_W-1:0] loops_left_q;

  timer_event_t events_due[$];
  int           mismatches;

  always @(posedge clk_i or negedge rst_ni) begin : timer_model
    logic [ACC_W:0] sum_us;
    timer_event_t   held;
    timer_event_t   seen;
    timer_event_t   want;
    int             fires;
    if (!rst_ni) begin
      interval_q    = '0;
      loop_count_q  = '0;
      tag_q         = '0;
      running_q     = 1'b0;
      acc_us_q      = '0;
      loops_left_q  = '0;
      events_due.delete();
      mismatches    = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // compare the result beat before queueing anything new this edge
      if (out_valid_i && !out_stall_i) begin
        seen = '{kind: kind_i, tag: tag_i, last: last_i};
        if (events_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: actual kind=%0b tag=%02h last=%0b",
                   $time, seen.kind, seen.tag, seen.last);
        end else begin
          want = events_due.pop_front();
          if (seen != want) begin
            mismatches++;
            $display("%0t: result mismatch: expected kind=%0b tag=%02h last=%0b, actual kind=%0b tag=%02h last=%0b",
                     $time, want.kind, want.tag, want.last, seen.kind, seen.tag, seen.last);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_INTERVAL: interval_q = cfg_wdata_i;
          REG_LOOPS: begin
            loop_count_q = cfg_wdata_i[LOOPS_W-1:0];
            loops_left_q = cfg_wdata_i[LOOPS_W-1:0];
          end
          REG_TAG: tag_q = cfg_wdata_i[TAG_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_START: running_q = 1'b1;
          CMD_PAUSE: running_q = 1'b0;
          CMD_STOP: begin
            running_q    = 1'b0;
            acc_us_q     = '0;
            loops_left_q = loop_count_q;
          end
          CMD_REWIND: begin
            acc_us_q     = '0;
            loops_left_q = loop_count_q;
          end
          CMD_TICK: begin
            if (running_q && interval_q != '0) begin
              sum_us   = acc_us_q + elapsed_us_i;
              acc_us_q = (sum_us > ACC_CEILING) ? ACC_CEILING : sum_us[ACC_W-1:0];
              if (loops_left_q == 0) begin
                // final firing: fire, then stop and rewind
                if (acc_us_q >= interval_q) begin
                  events_due.push_back('{kind: KIND_FIRE, tag: tag_q, last: 1'b0});
                  running_q    = 1'b0;
                  acc_us_q     = '0;
                  loops_left_q = loop_count_q;
                  events_due.push_back('{kind: KIND_STOP, tag: tag_q, last: 1'b1});
                end
              end else begin
                // hold each fire back one step so the final one gets the last flag
                fires = 0;
                held  = '0;
                while (fires < MAX_FIRES && loops_left_q != 0 && acc_us_q >= interval_q) begin
                  acc_us_q = acc_us_q - interval_q;
                  if (loops_left_q > 0) loops_left_q = loops_left_q - 1;
                  if (fires > 0) events_due.push_back(held);
                  held = '{kind: KIND_FIRE, tag: tag_q, last: 1'b0};
                  fires++;
                end
                if (fires > 0) begin
                  held.last = 1'b1;
                  events_due.push_back(held);
                end
              end
            end
          end
          default: ;
        endcase
      end

      error_count_o <= mismatches;
      pending_o     <= events_due.size();
    end
  end

endmodule

>>> tb/repeat_count_interval_timer_tb.sv
`timescale 1ns / 1ps

module repeat_count_interval_timer_tb;
  import rcit_pkg::*;

  localparam int unsigned FIRE_LIMIT = 63;
  // index with no register behind it
  localparam logic [1:0]  REG_SPARE = 2'd3;
  // command codes the block must ignore
  localparam logic [2:0]  CMD_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNKNOWN_LAST  = 3'd7;
  // cycles a no-result tick may still occupy the block after its beat
  localparam int          TICK_SETTLE = 4;
  localparam int          RANDOM_PHASES = 7;
  localparam int          BEATS_PER_PHASE = 13;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_index_i;
  logic [INTERVAL_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [2:0]            command_i;
  logic [INTERVAL_W-1:0] elapsed_us_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  kind_o;
  logic [TAG_W-1:0]      tag_o;
  logic                  last_o;

  // when set, neither side idles
  logic calm;

  int mismatch_count;
  int results_pending;

  repeat_count_interval_timer #(
    .MAX_FIRES (FIRE_LIMIT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .elapsed_us_i (elapsed_us_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .tag_o        (tag_o),
    .last_o       (last_o)
  );

  repeat_count_interval_timer_checker #(
    .MAX_FIRES (FIRE_LIMIT)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .elapsed_us_i  (elapsed_us_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .tag_i         (tag_o),
    .last_i        (last_o),
    .error_count_o (mismatch_count),
    .pending_o     (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall about 27 beats in a hundred, never while calm.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= !calm && ($urandom_range(99) < 27);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Present one command beat and hold it until the block takes it. Idle at
  // random first, so gaps land on every phase of the block's work.
  task automatic send_beat(input logic [2:0] cmd, input logic [INTERVAL_W-1:0] elapsed);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    elapsed_us_i <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Write all registers back to back, plus a write to the unused index that
  // must change nothing. Upper data bits beyond each register get random junk.
  task automatic program_timer(input logic [INTERVAL_W-1:0] interval, input int loops,
                               input logic [TAG_W-1:0] tag);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_INTERVAL;
    cfg_wdata_i <= interval;
    @(posedge clk_i);
    cfg_index_i <= REG_LOOPS;
    cfg_wdata_i <= {15'($urandom()), 17'(loops)};
    @(posedge clk_i);
    cfg_index_i <= REG_TAG;
    cfg_wdata_i <= {24'($urandom()), tag};
    @(posedge clk_i);
    cfg_index_i <= REG_SPARE;
    cfg_wdata_i <= $urandom();
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let a trailing
  // no-result tick finish its compare cycle before anything is rewritten.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (TICK_SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [INTERVAL_W-1:0] interval;
    logic [INTERVAL_W-1:0] span;
    logic [INTERVAL_W-1:0] elapsed;
    int                    loops;
    int                    pick;

    calm         <= 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_INTERVAL;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_TICK;
    elapsed_us_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Counted loops: paused ticks add nothing, the count reaches zero inside
    // a tick without a stop, the next whole interval fires and stops.
    program_timer(32'd10, 2, 8'hA5);
    send_beat(CMD_TICK, 32'd100);
    send_beat(CMD_START, $urandom());
    send_beat(CMD_TICK, 32'd25);
    send_beat(CMD_TICK, 32'd5);
    for (int c = CMD_UNKNOWN_FIRST; c <= CMD_UNKNOWN_LAST; c++) begin
      send_beat(3'(c), 32'hFFFF_FFFF);
    end
    // full-range elapsed time, then pause, stop and rewind clearing the sum
    send_beat(CMD_START, '0);
    send_beat(CMD_TICK, 32'hFFFF_FFFF);
    send_beat(CMD_TICK, 32'hFFFF_FFFF);
    send_beat(CMD_START, '0);
    send_beat(CMD_PAUSE, '0);
    send_beat(CMD_TICK, 32'd30);
    send_beat(CMD_START, '0);
    send_beat(CMD_TICK, 32'd7);
    send_beat(CMD_STOP, '0);
    send_beat(CMD_START, '0);
    send_beat(CMD_TICK, 32'd7);
    send_beat(CMD_REWIND, '0);
    send_beat(CMD_TICK, 32'd7);
    drain();

    // Repeat forever at the smallest interval: each tick hits the fire limit,
    // the third saturates the accumulator, a zero tick still drains surplus.
    program_timer(32'd1, -1, 8'hFF);
    send_beat(CMD_START, '0);
    repeat (3) send_beat(CMD_TICK, 32'hFFFF_FFFF);
    send_beat(CMD_TICK, '0);
    drain();

    // Zero interval disables ticks; then the largest interval with the most
    // negative count (still repeats forever).
    program_timer('0, 65535, 8'h00);
    send_beat(CMD_TICK, 32'd100);
    drain();
    program_timer(32'hFFFF_FFFF, -65536, 8'h3C);
    send_beat(CMD_TICK, 32'hFFFF_FFFF);
    drain();

    // Count zero from the start: a single fire plus stop.
    program_timer(32'd3, 0, 8'h5A);
    send_beat(CMD_START, '0);
    send_beat(CMD_TICK, 32'd2);
    send_beat(CMD_TICK, 32'd1);
    drain();

    // Random phases: mostly small intervals and counts so loops actually run
    // out, with extremes and full-range values mixed in. One phase runs calm.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(9))
        0:       interval = '0;
        1:       interval = 32'hFFFF_FFFF;
        2:       interval = $urandom();
        default: interval = $urandom_range(40, 1);
      endcase
      case ($urandom_range(9))
        0:       loops = -1;
        1:       loops = 65535;
        2:       loops = -65536;
        3:       loops = $urandom_range(131071);
        default: loops = $urandom_range(6);
      endcase
      program_timer(interval, loops, 8'($urandom_range(255)));
      calm <= (p == RANDOM_PHASES / 2);
      span = (interval > 32'd1000) ? 32'd2000 : 2 * interval + 1;
      send_beat(CMD_START, $urandom());
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        case ($urandom_range(9))
          0:       elapsed = $urandom();
          1:       elapsed = 32'hFFFF_FFFF;
          2:       elapsed = '0;
          default: elapsed = $urandom_range(span);
        endcase
        if (pick < 60)      send_beat(CMD_TICK, elapsed);
        else if (pick < 72) send_beat(CMD_START, elapsed);
        else if (pick < 78) send_beat(CMD_PAUSE, elapsed);
        else if (pick < 83) send_beat(CMD_STOP, elapsed);
        else if (pick < 90) send_beat(CMD_REWIND, elapsed);
        else send_beat(3'($urandom_range(CMD_UNKNOWN_LAST, CMD_UNKNOWN_FIRST)), elapsed);
      end
      drain();
    end

    // Advance past the block's latency so a stray late beat still gets caught.
    calm <= 1'b0;
    repeat (4 * TICK_SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
